### rtl/rectangle_fill_clip_scanner_top_defines.svh
// ---------------------------------------------------------------------------
// Rectangle fill scanner: assertion macros
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ---------------------------------------------------------------------------
`ifndef RECTANGLE_FILL_CLIP_SCANNER_TOP_DEFINES_SVH
`define RECTANGLE_FILL_CLIP_SCANNER_TOP_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define RFCS_ASSERT_SAME(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (trig) |-> (cond)) else $error(msg);

// Condition holds in the cycle after the trigger.
`define RFCS_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (trig) |=> (cond)) else $error(msg);

`endif

### rtl/rfcs_pkg.sv
// ---------------------------------------------------------------------------
// Rectangle fill scanner package
// Operation and scan mode codes, default widths, shared types.
// ---------------------------------------------------------------------------
`default_nettype none

package rfcs_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int COLOR_BITS_DEF = 16;
    localparam int OP_BITS        = 3;
    localparam int MODE_BITS      = 2;

    localparam logic [OP_BITS-1:0] OP_STEP         = 3'd0;
    localparam logic [OP_BITS-1:0] OP_START_COL    = 3'd1;
    localparam logic [OP_BITS-1:0] OP_START_ROW    = 3'd2;
    localparam logic [OP_BITS-1:0] OP_START_INSIDE = 3'd3;
    localparam logic [OP_BITS-1:0] OP_START_OUTSIDE = 3'd4;

    localparam logic [MODE_BITS-1:0] MODE_COL     = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_ROW     = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_INSIDE  = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_OUTSIDE = 2'd3;

    typedef struct packed {
        logic write_enable;
        logic done;
    } rfcs_flags_t;

endpackage

`default_nettype wire

### rtl/rectangle_fill_clip_scanner_top.sv
// ---------------------------------------------------------------------------
// Rectangle fill scanner with clip window
// Start transactions load a rectangle fill; step transactions emit pixels.
// ---------------------------------------------------------------------------
//  channel   | direction | payload
//  s_axis    | in        | tuser: operation; tdata: rectangle, color, clip window
//  m_axis    | out       | tdata: x, y, color; tuser: write enable; tlast: done
//
//  One transaction per cycle in while s_axis_tready is high; a step gives its
//  pixel in the cycle after accept. Scan position update and clip compares sit
//  between state and output registers: one pixel per cycle unless m_axis stalls.
//  Synchronous active-low reset clears the scanner to idle and the output empty.
//  A stalled output register holds; s_axis_tready follows it so nothing drops.
// ---------------------------------------------------------------------------
`default_nettype none

`include "rectangle_fill_clip_scanner_top_defines.svh"

module rectangle_fill_clip_scanner_top #(
    parameter int COORD_BITS = rfcs_pkg::COORD_BITS_DEF,
    parameter int COLOR_BITS = rfcs_pkg::COLOR_BITS_DEF,
    localparam int IN_DATA_BITS  = 8 * COORD_BITS + COLOR_BITS,
    localparam int IN_TDATA_W    = ((IN_DATA_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_BITS = 2 * COORD_BITS + COLOR_BITS,
    localparam int OUT_TDATA_W   = ((OUT_DATA_BITS + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // rect_left, rect_top, rect_right, rect_bottom, fill_color,
    // clip_left, clip_top, clip_right, clip_bottom
    input  logic [IN_TDATA_W-1:0]         s_axis_tdata,
    // operation
    input  logic [rfcs_pkg::OP_BITS-1:0]  s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // pixel_x, pixel_y, pixel_color
    output logic [OUT_TDATA_W-1:0]        m_axis_tdata,
    // write_enable
    output logic [0:0]                    m_axis_tuser,
    output logic                          m_axis_tlast
);

    logic                  item_en;
    logic                  res_valid;
    logic [COORD_BITS-1:0] res_x;
    logic [COORD_BITS-1:0] res_y;
    logic [COLOR_BITS-1:0] res_color;
    rfcs_pkg::rfcs_flags_t res_flags;

    logic                  m_valid_reg, m_valid_next;
    logic [COORD_BITS-1:0] m_x_reg;
    logic [COORD_BITS-1:0] m_y_reg;
    logic [COLOR_BITS-1:0] m_color_reg;
    rfcs_pkg::rfcs_flags_t m_flags_reg;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign item_en       = s_axis_tvalid && s_axis_tready;

    rfcs_scan_core #(
        .COORD_BITS (COORD_BITS),
        .COLOR_BITS (COLOR_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_en     (item_en),
        .op          (s_axis_tuser),
        .rect_left   (s_axis_tdata[0*COORD_BITS +: COORD_BITS]),
        .rect_top    (s_axis_tdata[1*COORD_BITS +: COORD_BITS]),
        .rect_right  (s_axis_tdata[2*COORD_BITS +: COORD_BITS]),
        .rect_bottom (s_axis_tdata[3*COORD_BITS +: COORD_BITS]),
        .fill_color  (s_axis_tdata[4*COORD_BITS +: COLOR_BITS]),
        .clip_left   (s_axis_tdata[4*COORD_BITS + COLOR_BITS +: COORD_BITS]),
        .clip_top    (s_axis_tdata[5*COORD_BITS + COLOR_BITS +: COORD_BITS]),
        .clip_right  (s_axis_tdata[6*COORD_BITS + COLOR_BITS +: COORD_BITS]),
        .clip_bottom (s_axis_tdata[7*COORD_BITS + COLOR_BITS +: COORD_BITS]),
        .res_valid   (res_valid),
        .res_x       (res_x),
        .res_y       (res_y),
        .res_color   (res_color),
        .res_flags   (res_flags)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (item_en && res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_en && res_valid) begin
            m_x_reg     <= res_x;
            m_y_reg     <= res_y;
            m_color_reg <= res_color;
            m_flags_reg <= res_flags;
        end
    end

    always_comb begin
        m_axis_tdata                      = '0;
        m_axis_tdata[OUT_DATA_BITS-1:0]   = {m_color_reg, m_y_reg, m_x_reg};
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tuser[0] = m_flags_reg.write_enable;
    assign m_axis_tlast    = m_flags_reg.done;

    `RFCS_ASSERT_NEXT(a_step_gives_pixel, item_en && (s_axis_tuser == rfcs_pkg::OP_STEP), m_axis_tvalid, "accepted step must produce an output transaction")
    `RFCS_ASSERT_NEXT(a_start_no_pixel, item_en && (s_axis_tuser != rfcs_pkg::OP_STEP) && !m_valid_reg, !m_axis_tvalid, "non-step transaction must not produce output")

endmodule

`default_nettype wire

### rtl/rfcs_scan_core.sv
// ---------------------------------------------------------------------------
// Rectangle fill scanner core
// Holds the fill state and works out one pixel position per step.
// ---------------------------------------------------------------------------
`default_nettype none

`include "rectangle_fill_clip_scanner_top_defines.svh"

module rfcs_scan_core #(
    parameter int COORD_BITS = rfcs_pkg::COORD_BITS_DEF,
    parameter int COLOR_BITS = rfcs_pkg::COLOR_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          item_en,
    input  logic [rfcs_pkg::OP_BITS-1:0]  op,
    input  logic [COORD_BITS-1:0]         rect_left,
    input  logic [COORD_BITS-1:0]         rect_top,
    input  logic [COORD_BITS-1:0]         rect_right,
    input  logic [COORD_BITS-1:0]         rect_bottom,
    input  logic [COLOR_BITS-1:0]         fill_color,
    input  logic [COORD_BITS-1:0]         clip_left,
    input  logic [COORD_BITS-1:0]         clip_top,
    input  logic [COORD_BITS-1:0]         clip_right,
    input  logic [COORD_BITS-1:0]         clip_bottom,
    output logic                          res_valid,
    output logic [COORD_BITS-1:0]         res_x,
    output logic [COORD_BITS-1:0]         res_y,
    output logic [COLOR_BITS-1:0]         res_color,
    output rfcs_pkg::rfcs_flags_t         res_flags
);

    logic                           fill_active_reg, fill_active_next;
    logic [rfcs_pkg::MODE_BITS-1:0] scan_mode_reg, scan_mode_next;
    logic [COORD_BITS-1:0]          cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0]          cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0]          left_reg, left_next;
    logic [COORD_BITS-1:0]          top_reg, top_next;
    logic [COORD_BITS-1:0]          right_reg, right_next;
    logic [COORD_BITS-1:0]          bottom_reg, bottom_next;
    logic [COLOR_BITS-1:0]          color_reg, color_next;
    logic [COORD_BITS-1:0]          clip_left_reg, clip_left_next;
    logic [COORD_BITS-1:0]          clip_top_reg, clip_top_next;
    logic [COORD_BITS-1:0]          clip_right_reg, clip_right_next;
    logic [COORD_BITS-1:0]          clip_bottom_reg, clip_bottom_next;

    logic                           is_start;
    logic                           is_step;
    logic [rfcs_pkg::MODE_BITS-1:0] start_mode;
    logic [COORD_BITS:0]            x_inc;
    logic [COORD_BITS:0]            y_inc;
    logic                           last_x;
    logic                           last_y;
    logic                           last_pos;
    logic                           in_win;
    logic                           pos_we;

    assign is_step = (op == rfcs_pkg::OP_STEP);

    always_comb begin
        is_start   = 1'b1;
        start_mode = rfcs_pkg::MODE_COL;
        unique case (op)
            rfcs_pkg::OP_START_COL:     start_mode = rfcs_pkg::MODE_COL;
            rfcs_pkg::OP_START_ROW:     start_mode = rfcs_pkg::MODE_ROW;
            rfcs_pkg::OP_START_INSIDE:  start_mode = rfcs_pkg::MODE_INSIDE;
            rfcs_pkg::OP_START_OUTSIDE: start_mode = rfcs_pkg::MODE_OUTSIDE;
            default:                    is_start   = 1'b0;
        endcase
    end

    // increments kept one bit wider so a right/bottom edge at the top of range compares
    assign x_inc    = {1'b0, cur_x_reg} + {{COORD_BITS{1'b0}}, 1'b1};
    assign y_inc    = {1'b0, cur_y_reg} + {{COORD_BITS{1'b0}}, 1'b1};
    assign last_x   = (x_inc >= {1'b0, right_reg});
    assign last_y   = (y_inc >= {1'b0, bottom_reg});
    assign last_pos = last_x && last_y;

    assign in_win = (cur_x_reg >= clip_left_reg) && (cur_x_reg <= clip_right_reg) &&
                    (cur_y_reg >= clip_top_reg) && (cur_y_reg <= clip_bottom_reg);

    always_comb begin
        unique case (scan_mode_reg)
            rfcs_pkg::MODE_INSIDE:  pos_we = in_win;
            rfcs_pkg::MODE_OUTSIDE: pos_we = !in_win;
            default:                pos_we = 1'b1;
        endcase
    end

    // idle step reports done with zeroed position and color
    assign res_valid              = is_step;
    assign res_x                  = fill_active_reg ? cur_x_reg : '0;
    assign res_y                  = fill_active_reg ? cur_y_reg : '0;
    assign res_color              = fill_active_reg ? color_reg : '0;
    assign res_flags.write_enable = fill_active_reg && pos_we;
    assign res_flags.done         = !fill_active_reg || last_pos;

    always_comb begin
        fill_active_next = fill_active_reg;
        scan_mode_next   = scan_mode_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        left_next        = left_reg;
        top_next         = top_reg;
        right_next       = right_reg;
        bottom_next      = bottom_reg;
        color_next       = color_reg;
        clip_left_next   = clip_left_reg;
        clip_top_next    = clip_top_reg;
        clip_right_next  = clip_right_reg;
        clip_bottom_next = clip_bottom_reg;
        if (item_en && is_start) begin
            scan_mode_next   = start_mode;
            left_next        = rect_left;
            top_next         = rect_top;
            right_next       = rect_right;
            bottom_next      = rect_bottom;
            color_next       = fill_color;
            clip_left_next   = clip_left;
            clip_top_next    = clip_top;
            clip_right_next  = clip_right;
            clip_bottom_next = clip_bottom;
            cur_x_next       = rect_left;
            cur_y_next       = rect_top;
            fill_active_next = (rect_left < rect_right) && (rect_top < rect_bottom);
        end else if (item_en && is_step && fill_active_reg) begin
            if (last_pos) begin
                fill_active_next = 1'b0;
            end else if (scan_mode_reg == rfcs_pkg::MODE_COL) begin
                if (last_y) begin
                    cur_y_next = top_reg;
                    cur_x_next = x_inc[COORD_BITS-1:0];
                end else begin
                    cur_y_next = y_inc[COORD_BITS-1:0];
                end
            end else begin
                if (last_x) begin
                    cur_x_next = left_reg;
                    cur_y_next = y_inc[COORD_BITS-1:0];
                end else begin
                    cur_x_next = x_inc[COORD_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_active_reg <= 1'b0;
            scan_mode_reg   <= rfcs_pkg::MODE_COL;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            left_reg        <= '0;
            top_reg         <= '0;
            right_reg       <= '0;
            bottom_reg      <= '0;
            color_reg       <= '0;
            clip_left_reg   <= '0;
            clip_top_reg    <= '0;
            clip_right_reg  <= '0;
            clip_bottom_reg <= '0;
        end else begin
            fill_active_reg <= fill_active_next;
            scan_mode_reg   <= scan_mode_next;
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            left_reg        <= left_next;
            top_reg         <= top_next;
            right_reg       <= right_next;
            bottom_reg      <= bottom_next;
            color_reg       <= color_next;
            clip_left_reg   <= clip_left_next;
            clip_top_reg    <= clip_top_next;
            clip_right_reg  <= clip_right_next;
            clip_bottom_reg <= clip_bottom_next;
        end
    end

    `RFCS_ASSERT_SAME(a_idle_step_done, !fill_active_reg, res_flags.done && !res_flags.write_enable, "idle scanner must report done without write")
    `RFCS_ASSERT_NEXT(a_empty_rect_idle, item_en && is_start && ((rect_left >= rect_right) || (rect_top >= rect_bottom)), !fill_active_reg, "empty rectangle must leave scanner idle")

endmodule

`default_nettype wire
